@@ rtl/periodic_report_scheduler_top_assert.svh @@
// Assertion macros for the periodic report scheduler.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef PERIODIC_REPORT_SCHEDULER_TOP_ASSERT_SVH
`define PERIODIC_REPORT_SCHEDULER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define PRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to another one on the next edge.
`define PRS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

@@ rtl/prs_pkg.sv @@
// Package of the periodic report scheduler: codes, defaults and reset tables.
// No dependencies.
`timescale 1ns / 1ps
package prs_pkg;

  localparam int NumSlotsDef      = 8;
  localparam int MaxParamsDef     = 16;
  localparam int PoolDepthDef     = 32;
  localparam int ValuesPerItemDef = 4;

  localparam logic [2:0] OP_ENABLE   = 3'd0;
  localparam logic [2:0] OP_DISABLE  = 3'd1;
  localparam logic [2:0] OP_INTERVAL = 3'd2;
  localparam logic [2:0] OP_TICK     = 3'd3;
  localparam logic [2:0] OP_POOL_WR  = 3'd4;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] echo_header;
    logic [7:0]  report_tag;
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic [63:0] value_c;
    logic [63:0] value_d;
    logic [2:0]  values_used;
    logic        report_end;
    logic        last;
  } result_t;

  function automatic logic [7:0] init_tag(int s);
    logic [7:0] r;
    r = 8'd0;
    case (s)
      0: r = 8'd0;
      1: r = 8'd1;
      2: r = 8'd11;
      3: r = 8'd100;
      4: r = 8'd110;
      5: r = 8'd120;
      6: r = 8'd200;
      7: r = 8'd210;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] init_interval(int s);
    logic [15:0] r;
    r = 16'd0;
    if (s == 0) r = 16'd2;
    else if (s == 1) r = 16'd10;
    else if (s < 8) r = 16'd60;
    return r;
  endfunction

  function automatic logic [4:0] init_count(int s);
    logic [4:0] r;
    r = 5'd0;
    case (s)
      0: r = 5'd1;
      2: r = 5'd5;
      1, 3, 4, 5, 6, 7: r = 5'd2;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] init_map(int s, int j);
    logic [4:0] r;
    r = 5'd0;
    case (s)
      0: r = 5'd0;
      1: if (j < 2) r = 5'(4 + j);
      2: if (j < 5) r = 5'(8 + j);
      3, 4, 5, 6, 7: if (j < 2) r = 5'(13 + 2 * (s - 3) + j);
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic int find_slot(logic [7:0] id, int n);
    int r;
    r = -1;
    for (int s = n - 1; s >= 0; s--) begin
      if (init_tag(s) == id) r = s;
    end
    return r;
  endfunction

endpackage

@@ rtl/prs_if.sv @@
// Handshake channels of the periodic report scheduler: command in, result out.
// No dependencies.
`timescale 1ns / 1ps
interface prs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  report_id;
  logic [15:0] new_interval;
  logic [31:0] command_header;
  logic [4:0]  pool_slot;
  logic [63:0] pool_data;
  modport source (output valid, op, report_id, new_interval, command_header, pool_slot,
                  pool_data, input ready);
  modport sink (input valid, op, report_id, new_interval, command_header, pool_slot,
                pool_data, output ready);
endinterface

interface prs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] echo_header;
  logic [7:0]  report_tag;
  logic [63:0] value_a;
  logic [63:0] value_b;
  logic [63:0] value_c;
  logic [63:0] value_d;
  logic [2:0]  values_used;
  logic        report_end;
  logic        last;
  modport source (output valid, kind, echo_header, report_tag, value_a, value_b, value_c,
                  value_d, values_used, report_end, last, input ready);
  modport sink (input valid, kind, echo_header, report_tag, value_a, value_b, value_c,
                value_d, values_used, report_end, last, output ready);
endinterface

@@ rtl/periodic_report_scheduler_top.sv @@
// Periodic report scheduler top level: slot state, parameter pool, tick sequencer.
// Depends on prs_pkg, prs_if.sv and periodic_report_scheduler_top_assert.svh.
//
//   channel | dir | carries
//   in_i    | in  | command, tick or pool write item
//   out_o   | out | accept/reject answer or report item
//
// Commands and pool writes are handled in the idle state. A tick visits the slots in
// order; for each due slot it reads each pool value in a read and a capture state
// (registered pool port), pushes each report item, and ends with a flush state.
// Reset clears the pool valid bits and restores the slot table at once.
// A full output register stalls the sequencer; input is taken only when idle.
`timescale 1ns / 1ps
module periodic_report_scheduler_top
  import prs_pkg::*;
#(
  parameter int NUM_SLOTS       = NumSlotsDef,
  parameter int MAX_PARAMS      = MaxParamsDef,
  parameter int POOL_DEPTH      = PoolDepthDef,
  parameter int VALUES_PER_ITEM = ValuesPerItemDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  prs_in_if.sink    in_i,
  prs_out_if.source out_o
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PW = $clog2(POOL_DEPTH);

  typedef enum logic [2:0] {ST_IDLE, ST_SLOT, ST_RD, ST_CAP, ST_PUSH, ST_FLUSH} state_e;

  state_e             st_q;
  logic               enabled_q  [NUM_SLOTS];
  logic [15:0]        interval_q [NUM_SLOTS];
  logic [15:0]        ticks_q    [NUM_SLOTS];
  logic [POOL_DEPTH-1:0] pool_vld_q;
  logic [63:0]        pool_mem [POOL_DEPTH];
  logic [63:0]        pool_rd_q;
  logic               pool_ok_q;
  logic [SW-1:0]      s_q;
  logic [4:0]         cnt_q, done_q;
  logic [2:0]         v_q, take_q;
  logic [63:0]        vals_q [4];
  result_t            out_q, pend_q;
  logic               out_valid_q, pend_valid_q;

  logic               in_acc, out_free, pool_we, cmd_ok;
  logic [4:0]         rd_idx, ticks_inc_unused;
  logic [PW-1:0]      rd_addr, wr_addr;
  logic [15:0]        tnew;
  logic [4:0]         cnt_clamp, rem;
  logic [2:0]         take_first, take_next;
  logic [4:0]         done_next;
  int                 hit;
  result_t            item;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (st_q == ST_IDLE) && out_free;
  assign in_acc    = in_i.valid && in_i.ready;
  assign hit       = find_slot(in_i.report_id, NUM_SLOTS);
  assign cmd_ok    = (in_i.op == OP_ENABLE || in_i.op == OP_DISABLE ||
                      in_i.op == OP_INTERVAL) && (hit >= 0);
  assign wr_addr   = PW'(in_i.pool_slot);
  assign pool_we   = in_acc && (in_i.op == OP_POOL_WR) && (32'(in_i.pool_slot) < POOL_DEPTH);

  assign rd_idx  = init_map(int'(s_q), int'(done_q) + int'(v_q));
  assign rd_addr = PW'(rd_idx);
  assign ticks_inc_unused = 5'd0;

  assign tnew      = (ticks_q[s_q] == 16'hFFFF) ? ticks_q[s_q] : ticks_q[s_q] + 16'd1;
  assign cnt_clamp = (32'(init_count(int'(s_q))) > MAX_PARAMS) ? 5'(MAX_PARAMS)
                                                               : init_count(int'(s_q));
  assign take_first = (32'(cnt_clamp) > VALUES_PER_ITEM) ? 3'(VALUES_PER_ITEM)
                                                         : 3'(cnt_clamp);
  assign done_next = done_q + 5'(take_q);
  assign rem       = cnt_q - done_next;
  assign take_next = (32'(rem) > VALUES_PER_ITEM) ? 3'(VALUES_PER_ITEM) : 3'(rem);

  always_comb begin
    item             = '0;
    item.kind        = KIND_REPORT;
    item.report_tag  = init_tag(int'(s_q));
    item.value_a     = vals_q[0];
    item.value_b     = vals_q[1];
    item.value_c     = vals_q[2];
    item.value_d     = vals_q[3];
    item.values_used = take_q;
    item.report_end  = (done_next >= cnt_q);
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[wr_addr] <= in_i.pool_data;
    end
    pool_rd_q <= pool_mem[rd_addr];
    pool_ok_q <= (32'(rd_idx) < POOL_DEPTH) && pool_vld_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      pend_q       <= '0;
      pool_vld_q   <= '0;
      s_q          <= '0;
      cnt_q        <= '0;
      done_q       <= '0;
      v_q          <= '0;
      take_q       <= '0;
      for (int k = 0; k < 4; k++) vals_q[k] <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        enabled_q[s]  <= (s < 2);
        interval_q[s] <= init_interval(s);
        ticks_q[s]    <= '0;
      end
    end else begin
      if (out_o.ready) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.op == OP_TICK) begin
              s_q  <= '0;
              st_q <= ST_SLOT;
            end else if (in_i.op == OP_POOL_WR) begin
              if (pool_we) pool_vld_q[wr_addr] <= 1'b1;
            end else begin
              out_valid_q <= 1'b1;
              out_q       <= '{kind: (cmd_ok ? KIND_ACCEPT : KIND_REJECT),
                               echo_header: in_i.command_header,
                               last: 1'b1,
                               default: '0};
              if (cmd_ok) begin
                if (in_i.op == OP_INTERVAL) begin
                  interval_q[SW'(hit)] <= in_i.new_interval;
                end else begin
                  enabled_q[SW'(hit)] <= (in_i.op == OP_ENABLE);
                  ticks_q[SW'(hit)]   <= '0;
                end
              end
            end
          end
        end
        ST_SLOT: begin
          if (enabled_q[s_q]) begin
            ticks_q[s_q] <= tnew;
          end
          if (enabled_q[s_q] && tnew >= interval_q[s_q]) begin
            cnt_q  <= cnt_clamp;
            done_q <= '0;
            v_q    <= '0;
            take_q <= take_first;
            for (int k = 0; k < 4; k++) vals_q[k] <= '0;
            st_q   <= (take_first == 3'd0) ? ST_PUSH : ST_RD;
          end else if (32'(s_q) == NUM_SLOTS - 1) begin
            st_q <= ST_FLUSH;
          end else begin
            s_q <= s_q + SW'(1);
          end
        end
        ST_RD: begin
          st_q <= ST_CAP;
        end
        ST_CAP: begin
          vals_q[v_q[1:0]] <= pool_ok_q ? pool_rd_q : 64'd0;
          v_q  <= v_q + 3'd1;
          st_q <= (v_q + 3'd1 == take_q) ? ST_PUSH : ST_RD;
        end
        ST_PUSH: begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_q       <= pend_q;
              out_valid_q <= 1'b1;
            end
            pend_q       <= item;
            pend_valid_q <= 1'b1;
            done_q       <= done_next;
            if (done_next >= cnt_q) begin
              ticks_q[s_q] <= '0;
              if (32'(s_q) == NUM_SLOTS - 1) begin
                st_q <= ST_FLUSH;
              end else begin
                s_q  <= s_q + SW'(1);
                st_q <= ST_SLOT;
              end
            end else begin
              v_q    <= '0;
              take_q <= take_next;
              for (int k = 0; k < 4; k++) vals_q[k] <= '0;
              st_q   <= ST_RD;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            st_q <= ST_IDLE;
          end else if (out_free) begin
            out_q        <= result_t'({pend_q[$bits(result_t)-1:1], 1'b1});
            out_valid_q  <= 1'b1;
            pend_valid_q <= 1'b0;
            st_q         <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.echo_header = out_q.echo_header;
  assign out_o.report_tag  = out_q.report_tag;
  assign out_o.value_a     = out_q.value_a;
  assign out_o.value_b     = out_q.value_b;
  assign out_o.value_c     = out_q.value_c;
  assign out_o.value_d     = out_q.value_d;
  assign out_o.values_used = out_q.values_used;
  assign out_o.report_end  = out_q.report_end;
  assign out_o.last        = out_q.last | (|ticks_inc_unused);

`include "periodic_report_scheduler_top_assert.svh"

  `PRS_ASSERT(a_ready_idle, !in_i.ready || st_q == ST_IDLE, "input ready outside idle")
  `PRS_ASSERT(a_idle_no_pend, st_q != ST_IDLE || !pend_valid_q, "item left pending in idle")
  `PRS_ASSERT(a_done_range, done_q <= cnt_q && 32'(cnt_q) <= MAX_PARAMS, "value count overrun")
  `PRS_ASSERT_NEXT(a_tick_starts, in_acc && in_i.op == OP_TICK, st_q == ST_SLOT && s_q == '0,
                   "tick did not start at first slot")

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for periodic_report_scheduler_top: drives commands, ticks and
// pool writes, predicts answers and report items, and compares them in order.
// Depends on prs_pkg, prs_if.sv and the scheduler RTL.
`timescale 1ns / 1ps
module tb_top;
  import prs_pkg::*;

  localparam logic [2:0] OP_BAD_A = 3'd5;
  localparam logic [2:0] OP_BAD_B = 3'd6;
  localparam logic [2:0] OP_BAD_C = 3'd7;
  localparam int         SLOTS    = 8;
  localparam int         STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  report_id;
    logic [15:0] new_interval;
    logic [31:0] command_header;
    logic [4:0]  pool_slot;
    logic [63:0] pool_data;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  prs_in_if  cmd_if ();
  prs_out_if res_if ();

  periodic_report_scheduler_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  always #2 clk_i = ~clk_i;

  command_t cmd_pending[$];
  result_t  result_expected[$];
  int       errors = 0;
  int       accepted = 0;
  int       quiet_cycles = 0;
  int       mode = 0;
  bit       cmd_taken = 1'b0;

  logic [7:0]  hk_tag   [SLOTS];
  logic        hk_on    [SLOTS];
  logic [15:0] hk_intv  [SLOTS];
  logic [15:0] hk_ticks [SLOTS];
  logic [4:0]  hk_count [SLOTS];
  logic [4:0]  hk_map   [SLOTS][16];
  logic [63:0] hk_pool  [32];

  task automatic restore_slots();
    logic [7:0]  tags [SLOTS];
    logic [15:0] ivs  [SLOTS];
    logic [4:0]  cnts [SLOTS];
    tags = '{8'd0, 8'd1, 8'd11, 8'd100, 8'd110, 8'd120, 8'd200, 8'd210};
    ivs  = '{16'd2, 16'd10, 16'd60, 16'd60, 16'd60, 16'd60, 16'd60, 16'd60};
    cnts = '{5'd1, 5'd2, 5'd5, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2};
    for (int p = 0; p < 32; p++) hk_pool[p] = '0;
    for (int s = 0; s < SLOTS; s++) begin
      hk_tag[s] = tags[s];
      hk_on[s] = (s < 2);
      hk_intv[s] = ivs[s];
      hk_ticks[s] = '0;
      hk_count[s] = cnts[s];
      for (int j = 0; j < 16; j++) hk_map[s][j] = '0;
    end
    hk_map[1][0] = 5'd4;
    hk_map[1][1] = 5'd5;
    for (int j = 0; j < 5; j++) hk_map[2][j] = 5'(8 + j);
    for (int s = 3; s < SLOTS; s++) begin
      hk_map[s][0] = 5'(13 + 2 * (s - 3));
      hk_map[s][1] = 5'(14 + 2 * (s - 3));
    end
  endtask

  task automatic predict_results(command_t c);
    result_t r;
    int      hit;
    int      n;
    int      cnt;
    int      done;
    int      take;
    logic [63:0] v [4];
    hit = -1;
    n = 0;
    if (c.op == OP_ENABLE || c.op == OP_DISABLE || c.op == OP_INTERVAL) begin
      for (int s = SLOTS - 1; s >= 0; s--) if (hk_tag[s] == c.report_id) hit = s;
      r = '0;
      r.echo_header = c.command_header;
      r.last = 1'b1;
      if (hit < 0) begin
        r.kind = KIND_REJECT;
      end else begin
        r.kind = KIND_ACCEPT;
        if (c.op == OP_INTERVAL) begin
          hk_intv[hit] = c.new_interval;
        end else begin
          hk_on[hit] = (c.op == OP_ENABLE);
          hk_ticks[hit] = '0;
        end
      end
      result_expected.push_back(r);
    end else if (c.op == OP_POOL_WR) begin
      hk_pool[c.pool_slot] = c.pool_data;
    end else if (c.op == OP_TICK) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (!hk_on[s]) continue;
        if (hk_ticks[s] != 16'hffff) hk_ticks[s]++;
        if (hk_ticks[s] < hk_intv[s]) continue;
        cnt = (hk_count[s] > 16) ? 16 : hk_count[s];
        done = 0;
        do begin
          take = (cnt - done > 4) ? 4 : cnt - done;
          for (int k = 0; k < 4; k++) v[k] = (k < take) ? hk_pool[hk_map[s][done + k]] : '0;
          r = '0;
          r.kind = KIND_REPORT;
          r.report_tag = hk_tag[s];
          r.value_a = v[0];
          r.value_b = v[1];
          r.value_c = v[2];
          r.value_d = v[3];
          r.values_used = 3'(take);
          done += take;
          r.report_end = (done >= cnt);
          result_expected.push_back(r);
          n++;
        end while (done < cnt);
        hk_ticks[s] = '0;
      end
      if (n > 0) result_expected[$].last = 1'b1;
    end else begin
      r = '0;
      r.kind = KIND_REJECT;
      r.echo_header = c.command_header;
      r.last = 1'b1;
      result_expected.push_back(r);
    end
  endtask

  task automatic compare_result();
    result_t e;
    if (result_expected.size() == 0) begin
      $error("unexpected result kind=%0d tag=%0d", res_if.kind, res_if.report_tag);
      errors++;
      return;
    end
    e = result_expected.pop_front();
    if (res_if.kind !== e.kind) begin
      $error("kind exp %0d got %0d", e.kind, res_if.kind); errors++;
    end
    if (res_if.echo_header !== e.echo_header) begin
      $error("echo_header exp %h got %h", e.echo_header, res_if.echo_header); errors++;
    end
    if (res_if.report_tag !== e.report_tag) begin
      $error("report_tag exp %0d got %0d", e.report_tag, res_if.report_tag); errors++;
    end
    if (res_if.value_a !== e.value_a) begin
      $error("value_a exp %h got %h", e.value_a, res_if.value_a); errors++;
    end
    if (res_if.value_b !== e.value_b) begin
      $error("value_b exp %h got %h", e.value_b, res_if.value_b); errors++;
    end
    if (res_if.value_c !== e.value_c) begin
      $error("value_c exp %h got %h", e.value_c, res_if.value_c); errors++;
    end
    if (res_if.value_d !== e.value_d) begin
      $error("value_d exp %h got %h", e.value_d, res_if.value_d); errors++;
    end
    if (res_if.values_used !== e.values_used) begin
      $error("values_used exp %0d got %0d", e.values_used, res_if.values_used); errors++;
    end
    if (res_if.report_end !== e.report_end) begin
      $error("report_end exp %0d got %0d", e.report_end, res_if.report_end); errors++;
    end
    if (res_if.last !== e.last) begin
      $error("last exp %0d got %0d", e.last, res_if.last); errors++;
    end
  endtask

  // Sample on the rising edge: predict accepted items, check results, watch for hangs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (cmd_if.valid && cmd_if.ready) begin
        predict_results(command_t'{cmd_if.op, cmd_if.report_id, cmd_if.new_interval,
                                   cmd_if.command_header, cmd_if.pool_slot,
                                   cmd_if.pool_data});
        cmd_taken = 1'b1;
        accepted++;
        mode = (accepted / 90) % 4;
        quiet_cycles = 0;
      end
      if (res_if.valid && res_if.ready) begin
        compare_result();
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Drive on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!cmd_if.valid || cmd_taken) begin
        cmd_taken = 1'b0;
        if (cmd_pending.size() > 0 &&
            !((mode == 1 && $urandom_range(99) < 66) || (mode == 3 && $urandom_range(99) < 10)))
        begin
          {cmd_if.op, cmd_if.report_id, cmd_if.new_interval, cmd_if.command_header,
           cmd_if.pool_slot, cmd_if.pool_data} <= cmd_pending.pop_front();
          cmd_if.valid <= 1'b1;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
      res_if.ready <= !((mode == 2 && $urandom_range(99) < 66) ||
                        (mode == 3 && $urandom_range(99) < 10));
    end
  end

  function automatic command_t make_cmd(logic [2:0] op, logic [7:0] id, logic [15:0] iv,
                                        logic [4:0] ps, logic [63:0] pd);
    command_t c;
    c.op = op;
    c.report_id = id;
    c.new_interval = iv;
    c.command_header = $urandom;
    c.pool_slot = ps;
    c.pool_data = pd;
    return c;
  endfunction

  function automatic command_t random_cmd();
    command_t   c;
    int         pick;
    logic [7:0] known [SLOTS];
    known = '{8'd0, 8'd1, 8'd11, 8'd100, 8'd110, 8'd120, 8'd200, 8'd210};
    pick = $urandom_range(99);
    c.command_header = $urandom;
    c.report_id = ($urandom_range(9) < 8) ? known[$urandom_range(SLOTS - 1)] : 8'($urandom);
    c.new_interval = ($urandom_range(9) < 8) ? 16'($urandom_range(6)) : 16'($urandom);
    c.pool_slot = 5'($urandom);
    c.pool_data = {$urandom, $urandom};
    if (pick < 40)      c.op = OP_TICK;
    else if (pick < 55) c.op = OP_POOL_WR;
    else if (pick < 70) c.op = OP_ENABLE;
    else if (pick < 78) c.op = OP_DISABLE;
    else if (pick < 92) c.op = OP_INTERVAL;
    else                c.op = 3'($urandom_range(5, 7));
    return c;
  endfunction

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.op = OP_TICK;
    cmd_if.report_id = '0;
    cmd_if.new_interval = '0;
    cmd_if.command_header = '0;
    cmd_if.pool_slot = '0;
    cmd_if.pool_data = '0;
    res_if.ready = 1'b0;
    restore_slots();
    // Directed: pool extremes, every command, unknown ids and ops, zero and max interval.
    cmd_pending.push_back(make_cmd(OP_POOL_WR, 8'd0, 16'd0, 5'd0, 64'hffff_ffff_ffff_ffff));
    cmd_pending.push_back(make_cmd(OP_POOL_WR, 8'd0, 16'd0, 5'd31, 64'h0));
    for (int p = 4; p < 23; p++)
      cmd_pending.push_back(make_cmd(OP_POOL_WR, 8'd0, 16'd0, 5'(p), {$urandom, $urandom}));
    cmd_pending.push_back(make_cmd(OP_TICK, 8'd0, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_TICK, 8'd0, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_ENABLE, 8'd11, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_INTERVAL, 8'd11, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_ENABLE, 8'd255, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_DISABLE, 8'd1, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_INTERVAL, 8'd0, 16'hffff, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_TICK, 8'd0, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_INTERVAL, 8'd0, 16'd1, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_BAD_A, 8'd0, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_BAD_B, 8'd0, 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_BAD_C, 8'hff, 16'hffff, 5'd31, '1));
    for (int s = 0; s < 4; s++)
      cmd_pending.push_back(make_cmd(OP_ENABLE, 8'(s == 0 ? 100 : s == 1 ? 120 : s == 2 ? 200
                                                     : 210), 16'd0, 5'd0, 64'd0));
    cmd_pending.push_back(make_cmd(OP_TICK, 8'd0, 16'd0, 5'd0, 64'd0));
    for (int i = 0; i < 330; i++) cmd_pending.push_back(random_cmd());
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (cmd_pending.size() == 0 && !cmd_if.valid);
    wait (result_expected.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && result_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/prs_pkg.sv
rtl/prs_if.sv
rtl/periodic_report_scheduler_top.sv
test/tb_top.sv
